// ===== rtl/ftg_pkg.sv =====
// Shared types, widths and constants of the FFT twiddle factor generator.
package ftg_pkg;

  localparam int unsigned MaxLog2Size   = 16;
  localparam int unsigned MinLog2Size   = 3;
  localparam int unsigned ResetLog2Size = 10;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned IFrac         = 30;

  localparam int unsigned CfgW   = 5;
  localparam int unsigned IndexW = 15;
  localparam int unsigned OutW   = 18;
  localparam int unsigned HalfW  = MaxLog2Size;
  localparam int unsigned PosW   = MaxLog2Size - MinLog2Size;
  localparam int unsigned AngW   = IFrac;
  localparam int unsigned AccW   = 32;
  localparam int unsigned TwoPiW = 33;

  // Fold, angle, square, six Horner steps and the output mapping.
  localparam int unsigned NumHorner = 6;
  localparam int unsigned NumStages = NumHorner + 4;

  localparam logic [TwoPiW-1:0] TwoPiQ30  = 33'd6746518852;
  localparam logic [AngW-1:0]   HalfR2Q30 = 30'd759250125;

  localparam logic signed [OutW-1:0] OutOne = OutW'(1) << FracBits;
  localparam logic signed [OutW-1:0] OutHalfR2 =
    OutW'((AccW'(HalfR2Q30) + (AccW'(1) << (IFrac - FracBits - 1))) >> (IFrac - FracBits));

  // Horner accumulators start at the top nonzero coefficient of each series.
  localparam logic signed [AccW-1:0] CosInit = 32'sd2;
  localparam logic signed [AccW-1:0] SinInit = -32'sd27;

  // Term added after each Horner product; the last sine step is the final
  // multiplication by the angle itself.
  localparam logic signed [AccW-1:0] CosAdd [NumHorner] = '{
    -32'sd296, 32'sd26631, -32'sd1491308, 32'sd44739243, -32'sd536870912, 32'sd1073741824
  };
  localparam logic signed [AccW-1:0] SinAdd [NumHorner] = '{
    32'sd2959, -32'sd213044, 32'sd8947849, -32'sd178956971, 32'sd1073741824, 32'sd0
  };

  typedef enum logic [2:0] {
    AnchNone = 3'd0,
    AnchOne  = 3'd1,
    AnchR    = 3'd2,
    AnchNegJ = 3'd3,
    AnchNegR = 3'd4
  } anchor_e;

  typedef enum logic [1:0] {
    Oct0 = 2'd0,
    Oct1 = 2'd1,
    Oct2 = 2'd2,
    Oct3 = 2'd3
  } oct_e;

  typedef struct packed {
    anchor_e anchor;
    oct_e    oct;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [PosW-1:0] pos;
  } fold_t;

  typedef struct packed {
    side_t                  side;
    logic [AngW-1:0]        x;
    logic [AngW-1:0]        x2;
    logic signed [AccW-1:0] cacc;
    logic signed [AccW-1:0] sacc;
  } hrn_t;

endpackage

// ===== rtl/ftg_cfg_if.sv =====
// Configuration write channel carrying the transform size.
interface ftg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ftg_pkg::CfgW-1:0]   log2_size;

  modport source (output valid, log2_size, input ready);
  modport sink   (input valid, log2_size, output ready);
endinterface

// ===== rtl/ftg_in_if.sv =====
// Input channel carrying one twiddle index per beat.
interface ftg_in_if;
  logic                       valid;
  logic                       ready;
  logic [ftg_pkg::IndexW-1:0] index;

  modport source (output valid, index, input ready);
  modport sink   (input valid, index, output ready);
endinterface

// ===== rtl/ftg_out_if.sv =====
// Output channel carrying one twiddle factor per beat.
interface ftg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ftg_pkg::OutW-1:0]   twiddle_real;
  logic signed [ftg_pkg::OutW-1:0]   twiddle_imag;

  modport source (output valid, twiddle_real, twiddle_imag, input ready);
  modport sink   (input valid, twiddle_real, twiddle_imag, output ready);
endinterface

// ===== rtl/ftg_fold.sv =====
// First stage: index masking, anchor detection and octant folding.
module ftg_fold (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ftg_pkg::CfgW-1:0]   lg_i,
  input  logic [ftg_pkg::IndexW-1:0] index_i,
  output ftg_pkg::fold_t             d_o
);

  logic [ftg_pkg::HalfW-1:0] half, mask, qtr, oct8, qe, k, t, t_sh;
  ftg_pkg::fold_t            d_d, d_q;

  always_comb begin
    half = ftg_pkg::HalfW'(1) << (lg_i - ftg_pkg::CfgW'(1));
    mask = half - ftg_pkg::HalfW'(1);
    qtr  = half >> 1;
    oct8 = half >> 2;
    qe   = qtr + oct8;
    k    = ftg_pkg::HalfW'(index_i) & mask;

    priority if (k == '0) begin
      d_d.side.anchor = ftg_pkg::AnchOne;
    end else if (k == oct8) begin
      d_d.side.anchor = ftg_pkg::AnchR;
    end else if (k == qtr) begin
      d_d.side.anchor = ftg_pkg::AnchNegJ;
    end else if (k == qe) begin
      d_d.side.anchor = ftg_pkg::AnchNegR;
    end else begin
      d_d.side.anchor = ftg_pkg::AnchNone;
    end

    priority if (k < oct8) begin
      d_d.side.oct = ftg_pkg::Oct0;
      t            = k;
    end else if (k < qtr) begin
      d_d.side.oct = ftg_pkg::Oct1;
      t            = qtr - k;
    end else if (k < qe) begin
      d_d.side.oct = ftg_pkg::Oct2;
      t            = k - qtr;
    end else begin
      d_d.side.oct = ftg_pkg::Oct3;
      t            = half - k;
    end

    // Scale the folded position to the largest size so the angle step
    // below divides by a fixed power of two.
    t_sh    = t << (ftg_pkg::CfgW'(ftg_pkg::MaxLog2Size) - lg_i);
    d_d.pos = t_sh[ftg_pkg::PosW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// ===== rtl/ftg_angle.sv =====
// Second and third stages: angle in Q0.30 and its rounded square.
module ftg_angle (
  input  logic           clk_i,
  input  logic [1:0]     en_i,
  input  ftg_pkg::fold_t d_i,
  output ftg_pkg::hrn_t  d_o
);

  localparam int unsigned ProdW = ftg_pkg::PosW + ftg_pkg::TwoPiW;
  localparam int unsigned SqW   = 2 * ftg_pkg::AngW + 1;

  logic [ProdW-1:0]          ang_sum;
  logic [SqW-1:0]            sq_sum;
  ftg_pkg::side_t            side2_q, side3_q;
  logic [ftg_pkg::AngW-1:0]  x2_d, x_q, x3_q, xsq_q;

  always_comb begin
    ang_sum = ProdW'(d_i.pos) * ProdW'(ftg_pkg::TwoPiQ30)
            + (ProdW'(1) << (ftg_pkg::MaxLog2Size - 1));
    x2_d    = ang_sum[ftg_pkg::MaxLog2Size +: ftg_pkg::AngW];
  end

  always_comb begin
    sq_sum = SqW'(x_q) * SqW'(x_q) + (SqW'(1) << (ftg_pkg::IFrac - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side2_q <= d_i.side;
      x_q     <= x2_d;
    end
    if (en_i[1]) begin
      side3_q <= side2_q;
      x3_q    <= x_q;
      xsq_q   <= sq_sum[ftg_pkg::IFrac +: ftg_pkg::AngW];
    end
  end

  always_comb begin
    d_o.side = side3_q;
    d_o.x    = x3_q;
    d_o.x2   = xsq_q;
    d_o.cacc = ftg_pkg::CosInit;
    d_o.sacc = ftg_pkg::SinInit;
  end

endmodule

// ===== rtl/ftg_horner.sv =====
// One Horner step of the cosine and sine series, one multiplier per lane.
module ftg_horner #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  ftg_pkg::hrn_t d_i,
  output ftg_pkg::hrn_t d_o
);

  localparam int unsigned ProdW = ftg_pkg::AngW + 1 + ftg_pkg::AccW;
  localparam bit          UseX  = (STEP == ftg_pkg::NumHorner - 1);
  localparam logic signed [ProdW-1:0] RndOff = ProdW'(1) << (ftg_pkg::IFrac - 1);

  logic signed [ftg_pkg::AngW:0]   c_op, s_op;
  logic signed [ProdW-1:0]         c_prod, s_prod, c_rnd, s_rnd;
  ftg_pkg::hrn_t                   d_d, d_q;

  // On the last step the sine lane multiplies by the angle, not its square.
  assign c_op = $signed({1'b0, d_i.x2});
  assign s_op = UseX ? $signed({1'b0, d_i.x}) : $signed({1'b0, d_i.x2});

  always_comb begin
    c_prod = c_op * d_i.cacc;
    s_prod = s_op * d_i.sacc;
    c_rnd  = c_prod + RndOff;
    s_rnd  = s_prod + RndOff;

    d_d      = d_i;
    d_d.cacc = $signed(c_rnd[ftg_pkg::IFrac +: ftg_pkg::AccW]) + ftg_pkg::CosAdd[STEP];
    d_d.sacc = $signed(s_rnd[ftg_pkg::IFrac +: ftg_pkg::AccW]) + ftg_pkg::SinAdd[STEP];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

// ===== rtl/ftg_map.sv =====
// Last stage: output rounding, octant expansion, anchors and output register.
module ftg_map (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  ftg_pkg::hrn_t                   d_i,
  output logic signed [ftg_pkg::OutW-1:0] re_o,
  output logic signed [ftg_pkg::OutW-1:0] im_o
);

  function automatic logic signed [ftg_pkg::OutW-1:0] to_out(
    input logic signed [ftg_pkg::AccW-1:0] v
  );
    logic signed [ftg_pkg::AccW-1:0] sum;
    logic signed [ftg_pkg::OutW-1:0] r;
    sum = v + (ftg_pkg::AccW'(1) << (ftg_pkg::IFrac - ftg_pkg::FracBits - 1));
    r   = $signed(sum[ftg_pkg::AccW-1:ftg_pkg::IFrac-ftg_pkg::FracBits]);
    if (r > ftg_pkg::OutOne) begin
      r = ftg_pkg::OutOne;
    end
    if (r < -ftg_pkg::OutOne) begin
      r = -ftg_pkg::OutOne;
    end
    return r;
  endfunction

  logic signed [ftg_pkg::OutW-1:0] c, s, re_d, im_d, re_q, im_q;

  always_comb begin
    c = to_out(d_i.cacc);
    s = to_out(d_i.sacc);
    unique case (d_i.side.anchor)
      ftg_pkg::AnchOne: begin
        re_d = ftg_pkg::OutOne;
        im_d = '0;
      end
      ftg_pkg::AnchR: begin
        re_d = ftg_pkg::OutHalfR2;
        im_d = -ftg_pkg::OutHalfR2;
      end
      ftg_pkg::AnchNegJ: begin
        re_d = '0;
        im_d = -ftg_pkg::OutOne;
      end
      ftg_pkg::AnchNegR: begin
        re_d = -ftg_pkg::OutHalfR2;
        im_d = -ftg_pkg::OutHalfR2;
      end
      ftg_pkg::AnchNone: begin
        unique case (d_i.side.oct)
          ftg_pkg::Oct0: begin
            re_d = c;
            im_d = -s;
          end
          ftg_pkg::Oct1: begin
            re_d = s;
            im_d = -c;
          end
          ftg_pkg::Oct2: begin
            re_d = -s;
            im_d = -c;
          end
          ftg_pkg::Oct3: begin
            re_d = -c;
            im_d = -s;
          end
          default: begin
            re_d = '0;
            im_d = '0;
          end
        endcase
      end
      default: begin
        re_d = '0;
        im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q <= re_d;
      im_q <= im_d;
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

// ===== rtl/fft_twiddle_generator_top.sv =====
// An accepted index beat passes the fold, angle, square, Horner and map registers in
// turn. Throughput: one index per cycle unless the output stalls; no stage has more
// than one multiplier on any path, and a stage refills as soon as the one after it
// moves or is empty. A stalled output holds its beat; earlier stages keep filling
// bubbles meanwhile. Reset clears all stage valid bits and sets log2_size to 10.
module fft_twiddle_generator_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  ftg_cfg_if.sink   cfg_i,
  ftg_in_if.sink    item_i,
  ftg_out_if.source result_o
);

  localparam int unsigned NS = ftg_pkg::NumStages;

  logic [ftg_pkg::CfgW-1:0]        lg_d, lg_q;
  logic [NS-1:0]                   vld_d, vld_q, rdy, en;
  ftg_pkg::fold_t                  fold_d;
  ftg_pkg::hrn_t                   hd [ftg_pkg::NumHorner+1];
  logic signed [ftg_pkg::OutW-1:0] re, im;

  // Out-of-range sizes are clamped when written.
  always_comb begin
    priority if (cfg_i.log2_size < ftg_pkg::CfgW'(ftg_pkg::MinLog2Size)) begin
      lg_d = ftg_pkg::CfgW'(ftg_pkg::MinLog2Size);
    end else if (cfg_i.log2_size > ftg_pkg::CfgW'(ftg_pkg::MaxLog2Size)) begin
      lg_d = ftg_pkg::CfgW'(ftg_pkg::MaxLog2Size);
    end else begin
      lg_d = cfg_i.log2_size;
    end
  end

  assign cfg_i.ready = 1'b1;

  // A stage takes a new beat when it is empty or its own beat moves on.
  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || result_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    en[0]    = rdy[0] && item_i.valid;
    vld_d[0] = rdy[0] ? item_i.valid : vld_q[0];
    for (int i = 1; i < NS; i++) begin
      en[i]    = rdy[i] && vld_q[i-1];
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= ftg_pkg::CfgW'(ftg_pkg::ResetLog2Size);
      vld_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        lg_q <= lg_d;
      end
      vld_q <= vld_d;
    end
  end

  ftg_fold u_fold (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .lg_i    (lg_q),
    .index_i (item_i.index),
    .d_o     (fold_d)
  );

  ftg_angle u_angle (
    .clk_i (clk_i),
    .en_i  (en[2:1]),
    .d_i   (fold_d),
    .d_o   (hd[0])
  );

  for (genvar j = 0; j < ftg_pkg::NumHorner; j++) begin : g_horner
    ftg_horner #(
      .STEP (j)
    ) u_horner (
      .clk_i (clk_i),
      .en_i  (en[3+j]),
      .d_i   (hd[j]),
      .d_o   (hd[j+1])
    );
  end

  ftg_map u_map (
    .clk_i (clk_i),
    .en_i  (en[NS-1]),
    .d_i   (hd[ftg_pkg::NumHorner]),
    .re_o  (re),
    .im_o  (im)
  );

  assign item_i.ready          = rdy[0];
  assign result_o.valid        = vld_q[NS-1];
  assign result_o.twiddle_real = re;
  assign result_o.twiddle_imag = im;

endmodule
